// ===== hdl/svpwm_pkg.sv =====
`timescale 1ns / 1ps

package svpwm_pkg;

	// sqrt3/2 and sqrt3, both scaled by 2^16
	localparam int HALF_SQRT3_Q16 = 56756;
	localparam int SQRT3_Q16      = 113512;

	// Fraction of the period in Q.24, scaled pair width and phase time width
	localparam int FRAC_W   = 24;
	localparam int SCALED_W = 38;
	localparam int RATIO_W  = 25;
	localparam int TIME_W   = 26;

	// Configuration register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_PWM_TOP    = 2'd0;
	localparam logic [1:0] REG_MOD_PERIOD = 2'd1;
	localparam logic [1:0] REG_BUS_MIN    = 2'd2;

	localparam int PWM_TOP_RST    = 8000;
	localparam int MOD_PERIOD_RST = 8000;
	localparam int BUS_MIN_RST    = 2560;

	// Sector codes; the two zero-vector codes give neutral compares
	localparam logic [2:0] SEC_Z0 = 3'd0;
	localparam logic [2:0] SEC_1  = 3'd1;
	localparam logic [2:0] SEC_2  = 3'd2;
	localparam logic [2:0] SEC_3  = 3'd3;
	localparam logic [2:0] SEC_4  = 3'd4;
	localparam logic [2:0] SEC_5  = 3'd5;
	localparam logic [2:0] SEC_6  = 3'd6;
	localparam logic [2:0] SEC_Z7 = 3'd7;

	typedef struct packed {
		logic [2:0] sector;
		logic       bus_low;
	} svpwm_ctl_t;

	typedef struct packed {
		svpwm_ctl_t           ctl;
		logic                 over;
		logic [RATIO_W-1:0]   r1_lo;
		logic [RATIO_W-1:0]   r2_lo;
	} svpwm_ovr_t;

endpackage

// ===== hdl/svpwm_front.sv =====
`timescale 1ns / 1ps

module svpwm_front #(
	parameter int VOLT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [VOLT_WIDTH-1:0]  v_alpha,
	input  logic signed [VOLT_WIDTH-1:0]  v_beta,
	input  logic [VOLT_WIDTH-1:0]         bus_voltage,
	input  logic [VOLT_WIDTH-1:0]         bus_minimum,
	output logic                          out_valid,
	output logic [VOLT_WIDTH+25:0]        num_1,
	output logic [VOLT_WIDTH+25:0]        num_2,
	output logic [VOLT_WIDTH-1:0]         vdc,
	output svpwm_pkg::svpwm_ctl_t         ctl
);

	localparam int PW = VOLT_WIDTH + 17;
	localparam int MW = VOLT_WIDTH + 16;
	localparam int ZW = VOLT_WIDTH + 18;
	localparam logic signed [PW-1:0] HALF_S = PW'(svpwm_pkg::HALF_SQRT3_Q16);
	localparam logic [16:0] SQ = 17'(svpwm_pkg::SQRT3_Q16);

	function automatic logic [MW-1:0] pos(input logic signed [PW-1:0] x);
		logic [MW-1:0] r;
		r = x[PW-1] ? '0 : x[MW-1:0];
		return r;
	endfunction

	// Stage 1: alpha times sqrt3/2, bus test
	logic signed [PW-1:0]         a_w;
	logic signed [PW-1:0]         pa_s1;
	logic signed [VOLT_WIDTH-1:0] b_s1;
	logic [VOLT_WIDTH-1:0]        vdc_s1;
	logic                         low_s1;
	logic                         valid_s1;

	assign a_w = PW'(v_alpha);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= a_w * HALF_S;
			b_s1   <= v_beta;
			vdc_s1 <= bus_voltage;
			low_s1 <= (bus_voltage <= bus_minimum);
		end
	end

	// Stage 2: reference projections, sector and active-vector operands
	logic signed [PW-1:0] b_w, hb, vr2, vr3, bb;
	logic [2:0]           sec;
	logic [MW-1:0]        m1, m2;
	logic [MW-1:0]        m1_s2, m2_s2;
	logic [VOLT_WIDTH-1:0] vdc_s2;
	svpwm_pkg::svpwm_ctl_t ctl_s2;
	logic                 valid_s2;

	always_comb begin
		b_w = PW'(b_s1);
		hb  = b_w <<< 15;
		bb  = b_w <<< 16;
		vr2 = pa_s1 - hb;
		vr3 = -pa_s1 - hb;
		sec = {vr3 > 0, vr2 > 0, b_s1 > 0};
		unique case (sec)
			svpwm_pkg::SEC_1: begin m1 = pos(-vr2); m2 = pos(-vr3); end
			svpwm_pkg::SEC_2: begin m1 = pos(-vr3); m2 = pos(-bb);  end
			svpwm_pkg::SEC_3: begin m1 = pos(vr2);  m2 = pos(bb);   end
			svpwm_pkg::SEC_4: begin m1 = pos(-bb);  m2 = pos(-vr2); end
			svpwm_pkg::SEC_5: begin m1 = pos(bb);   m2 = pos(vr3);  end
			svpwm_pkg::SEC_6: begin m1 = pos(vr3);  m2 = pos(vr2);  end
			default: begin m1 = '0; m2 = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2          <= m1;
			m2_s2          <= m2;
			vdc_s2         <= vdc_s1;
			ctl_s2.sector  <= low_s1 ? svpwm_pkg::SEC_Z0 : sec;
			ctl_s2.bus_low <= low_s1;
		end
	end

	// Stage 3: both halves of each operand times sqrt3
	logic [VOLT_WIDTH+16:0] ph1_s3, ph2_s3;
	logic [32:0]            pl1_s3, pl2_s3;
	logic [VOLT_WIDTH-1:0]  vdc_s3;
	svpwm_pkg::svpwm_ctl_t  ctl_s3;
	logic                   valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph1_s3 <= m1_s2[MW-1:16] * SQ;
			ph2_s3 <= m2_s2[MW-1:16] * SQ;
			pl1_s3 <= m1_s2[15:0] * SQ;
			pl2_s3 <= m2_s2[15:0] * SQ;
			vdc_s3 <= vdc_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: merge the halves into the dividend
	logic [ZW-1:0]         z1, z2;
	logic [ZW+7:0]         num1_s4, num2_s4;
	logic [VOLT_WIDTH-1:0] vdc_s4;
	svpwm_pkg::svpwm_ctl_t ctl_s4;
	logic                  valid_s4;

	assign z1 = ZW'(ph1_s3) + ZW'(pl1_s3[32:16]);
	assign z2 = ZW'(ph2_s3) + ZW'(pl2_s3[32:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s4 <= {z1, 8'b0};
			num2_s4 <= {z2, 8'b0};
			vdc_s4  <= vdc_s3;
			ctl_s4  <= ctl_s3;
		end
	end

	assign out_valid = valid_s4;
	assign num_1     = num1_s4;
	assign num_2     = num2_s4;
	assign vdc       = vdc_s4;
	assign ctl       = ctl_s4;

endmodule

// ===== hdl/svpwm_div.sv =====
`timescale 1ns / 1ps

// Two restoring dividers sharing one divisor, one quotient bit per stage.
// The dividend bits above QUO_W preload the remainder and must be below the divisor.
module svpwm_div #(
	parameter int NUM_W  = 42,
	parameter int DEN_W  = 16,
	parameter int QUO_W  = 42,
	parameter int SIDE_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num_a,
	input  logic [NUM_W-1:0]  num_b,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo_a,
	output logic [QUO_W-1:0]  quo_b,
	output logic [SIDE_W-1:0] side_out
);

	logic [DEN_W-1:0]  rem_a_s [QUO_W];
	logic [DEN_W-1:0]  rem_b_s [QUO_W];
	logic [QUO_W-1:0]  qn_a_s  [QUO_W];
	logic [QUO_W-1:0]  qn_b_s  [QUO_W];
	logic [DEN_W-1:0]  den_s   [QUO_W];
	logic [SIDE_W-1:0] side_s  [QUO_W];
	logic [QUO_W-1:0]  valid_s;

	logic [DEN_W-1:0]  rem_a_n [QUO_W];
	logic [DEN_W-1:0]  rem_b_n [QUO_W];
	logic [QUO_W-1:0]  qn_a_n  [QUO_W];
	logic [QUO_W-1:0]  qn_b_n  [QUO_W];
	logic [DEN_W-1:0]  den_n   [QUO_W];
	logic [SIDE_W-1:0] side_n  [QUO_W];
	logic [QUO_W-1:0]  valid_n;

	always_comb begin
		logic [DEN_W-1:0]  pra, prb, pd;
		logic [QUO_W-1:0]  pqa, pqb;
		logic [SIDE_W-1:0] ps;
		logic              pv;
		logic [DEN_W:0]    ta, tb, da, db;
		logic              ga, gb;
		for (int i = 0; i < QUO_W; i++) begin
			if (i == 0) begin
				pra = DEN_W'(num_a >> QUO_W);
				prb = DEN_W'(num_b >> QUO_W);
				pqa = num_a[QUO_W-1:0];
				pqb = num_b[QUO_W-1:0];
				pd  = den;
				ps  = side_in;
				pv  = in_valid;
			end else begin
				pra = rem_a_s[i-1];
				prb = rem_b_s[i-1];
				pqa = qn_a_s[i-1];
				pqb = qn_b_s[i-1];
				pd  = den_s[i-1];
				ps  = side_s[i-1];
				pv  = valid_s[i-1];
			end
			ta = {pra, pqa[QUO_W-1]};
			tb = {prb, pqb[QUO_W-1]};
			da = ta - {1'b0, pd};
			db = tb - {1'b0, pd};
			ga = (ta >= {1'b0, pd});
			gb = (tb >= {1'b0, pd});
			rem_a_n[i] = ga ? da[DEN_W-1:0] : ta[DEN_W-1:0];
			rem_b_n[i] = gb ? db[DEN_W-1:0] : tb[DEN_W-1:0];
			qn_a_n[i]  = {pqa[QUO_W-2:0], ga};
			qn_b_n[i]  = {pqb[QUO_W-2:0], gb};
			den_n[i]   = pd;
			side_n[i]  = ps;
			valid_n[i] = pv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= valid_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QUO_W; i++) begin
				rem_a_s[i] <= rem_a_n[i];
				rem_b_s[i] <= rem_b_n[i];
				qn_a_s[i]  <= qn_a_n[i];
				qn_b_s[i]  <= qn_b_n[i];
				den_s[i]   <= den_n[i];
				side_s[i]  <= side_n[i];
			end
		end
	end

	assign out_valid = valid_s[QUO_W-1];
	assign quo_a     = qn_a_s[QUO_W-1];
	assign quo_b     = qn_b_s[QUO_W-1];
	assign side_out  = side_s[QUO_W-1];

endmodule

// ===== hdl/svpwm_ovr.sv =====
`timescale 1ns / 1ps

module svpwm_ovr #(
	parameter int RAW_W = 42
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [RAW_W-1:0]                     r1,
	input  logic [RAW_W-1:0]                     r2,
	input  svpwm_pkg::svpwm_ctl_t                ctl,
	output logic                                 out_valid,
	output logic [svpwm_pkg::SCALED_W-1:0]       s1,
	output logic [svpwm_pkg::SCALED_W-1:0]       s2,
	output logic [svpwm_pkg::SCALED_W-1:0]       ssum,
	output svpwm_pkg::svpwm_ovr_t                side
);

	localparam int SW = svpwm_pkg::SCALED_W;
	// Number of right shifts worth trying; the largest one always fits
	localparam int KN = (RAW_W > SW - 1) ? RAW_W - SW + 2 : 1;
	localparam logic [RAW_W:0] ONE_Q24 = (RAW_W + 1)'(1) << svpwm_pkg::FRAC_W;

	// Stage 1: pair sums for every shift amount, overrun test
	logic [RAW_W:0]    cand [KN];
	logic [KN-1:0]     fit;

	always_comb begin
		for (int k = 0; k < KN; k++) begin
			cand[k] = (RAW_W + 1)'(r1 >> k) + (RAW_W + 1)'(r2 >> k);
			fit[k]  = ((cand[k] >> SW) == '0);
		end
	end

	logic [RAW_W-1:0]      r1_s1, r2_s1;
	logic [SW-1:0]         cand_s1 [KN];
	logic [KN-1:0]         fit_s1;
	logic                  over_s1;
	svpwm_pkg::svpwm_ctl_t ctl_s1;
	logic                  valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s1   <= r1;
			r2_s1   <= r2;
			fit_s1  <= fit;
			over_s1 <= (cand[0] > ONE_Q24);
			ctl_s1  <= ctl;
			for (int k = 0; k < KN; k++) begin
				cand_s1[k] <= cand[k][SW-1:0];
			end
		end
	end

	// Stage 2: the smallest shift that brings the sum below 2^38
	logic [SW-1:0] sh1, sh2, shs;

	always_comb begin
		sh1 = SW'(r1_s1 >> (KN - 1));
		sh2 = SW'(r2_s1 >> (KN - 1));
		shs = cand_s1[KN-1];
		for (int k = KN - 1; k >= 0; k--) begin
			if (fit_s1[k]) begin
				sh1 = SW'(r1_s1 >> k);
				sh2 = SW'(r2_s1 >> k);
				shs = cand_s1[k];
			end
		end
	end

	logic [SW-1:0]         s1_s2, s2_s2, sum_s2;
	svpwm_pkg::svpwm_ovr_t side_s2;
	logic                  valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s2         <= sh1;
			s2_s2         <= sh2;
			sum_s2        <= shs;
			side_s2.ctl   <= ctl_s1;
			side_s2.over  <= over_s1;
			side_s2.r1_lo <= r1_s1[svpwm_pkg::RATIO_W-1:0];
			side_s2.r2_lo <= r2_s1[svpwm_pkg::RATIO_W-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign s1        = s1_s2;
	assign s2        = s2_s2;
	assign ssum      = sum_s2;
	assign side      = side_s2;

endmodule

// ===== hdl/svpwm_back.sv =====
`timescale 1ns / 1ps

module svpwm_back #(
	parameter int COMPARE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [svpwm_pkg::RATIO_W-1:0]     q1,
	input  logic [svpwm_pkg::RATIO_W-1:0]     q2,
	input  svpwm_pkg::svpwm_ovr_t             side,
	input  logic [COMPARE_WIDTH-1:0]          pwm_top,
	input  logic [COMPARE_WIDTH-1:0]          modulation_period,
	output logic                              out_valid,
	output logic [COMPARE_WIDTH-1:0]          compare_u,
	output logic [COMPARE_WIDTH-1:0]          compare_v,
	output logic [COMPARE_WIDTH-1:0]          compare_w,
	output logic [2:0]                        sector_code,
	output logic                              bus_low
);

	localparam int RW = svpwm_pkg::RATIO_W;
	localparam int TW = svpwm_pkg::TIME_W;
	localparam int CW = COMPARE_WIDTH;
	localparam int PRW = TW + CW;
	localparam logic [TW-1:0] ONE_T = TW'(1) << svpwm_pkg::FRAC_W;
	localparam logic [PRW:0] HALF_LSB = (PRW + 1)'(1) << (TW - 1);

	// Stage 1: scaled or original active times
	logic [RW-1:0]         r1_s1, r2_s1;
	svpwm_pkg::svpwm_ctl_t ctl_s1;
	logic                  valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s1  <= side.over ? q1 : side.r1_lo;
			r2_s1  <= side.over ? q2 : side.r2_lo;
			ctl_s1 <= side.ctl;
		end
	end

	// Stage 2: centred phase times, mapped to phases by sector
	logic [TW-1:0] r1e, r2e, ta, tb, tc, tu, tv, tw;

	always_comb begin
		r1e = TW'(r1_s1);
		r2e = TW'(r2_s1);
		ta  = ONE_T - r1e - r2e;
		tb  = ONE_T + r1e - r2e;
		tc  = ONE_T + r1e + r2e;
		unique case (ctl_s1.sector)
			svpwm_pkg::SEC_1: begin tu = tb; tv = ta; tw = tc; end
			svpwm_pkg::SEC_2: begin tu = ta; tv = tc; tw = tb; end
			svpwm_pkg::SEC_3: begin tu = ta; tv = tb; tw = tc; end
			svpwm_pkg::SEC_4: begin tu = tc; tv = tb; tw = ta; end
			svpwm_pkg::SEC_5: begin tu = tc; tv = ta; tw = tb; end
			default:          begin tu = tb; tv = tc; tw = ta; end
		endcase
	end

	logic [TW-1:0]         tu_s2, tv_s2, tw_s2;
	svpwm_pkg::svpwm_ctl_t ctl_s2;
	logic                  valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tu_s2  <= tu;
			tv_s2  <= tv;
			tw_s2  <= tw;
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 3: times the modulation period
	logic [PRW-1:0]        pu_s3, pv_s3, pw_s3;
	svpwm_pkg::svpwm_ctl_t ctl_s3;
	logic                  valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s3  <= PRW'(tu_s2) * PRW'(modulation_period);
			pv_s3  <= PRW'(tv_s2) * PRW'(modulation_period);
			pw_s3  <= PRW'(tw_s2) * PRW'(modulation_period);
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: round half up, clamp to top and invert; neutral compares for a low bus or zero vector
	function automatic logic [CW-1:0] to_compare(input logic [PRW-1:0] p,
			input logic [CW-1:0] top);
		logic [PRW:0]  rnd;
		logic [CW:0]   c;
		logic [CW-1:0] cl;
		rnd = (PRW + 1)'(p) + HALF_LSB;
		c   = rnd[PRW:TW];
		cl  = (c > {1'b0, top}) ? top : c[CW-1:0];
		return top - cl;
	endfunction

	logic [CW-1:0] neutral;
	logic          go_neutral;

	assign neutral    = pwm_top >> 1;
	assign go_neutral = ctl_s3.bus_low || (ctl_s3.sector == svpwm_pkg::SEC_Z0) ||
		(ctl_s3.sector == svpwm_pkg::SEC_Z7);

	logic [CW-1:0] cu_s4, cv_s4, cw_s4;
	logic [2:0]    sec_s4;
	logic          low_s4;
	logic          valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s4  <= go_neutral ? neutral : to_compare(pu_s3, pwm_top);
			cv_s4  <= go_neutral ? neutral : to_compare(pv_s3, pwm_top);
			cw_s4  <= go_neutral ? neutral : to_compare(pw_s3, pwm_top);
			sec_s4 <= ctl_s3.sector;
			low_s4 <= ctl_s3.bus_low;
		end
	end

	assign out_valid   = valid_s4;
	assign compare_u   = cu_s4;
	assign compare_v   = cv_s4;
	assign compare_w   = cw_s4;
	assign sector_code = sec_s4;
	assign bus_low     = low_s4;

endmodule

// ===== hdl/svpwm_compare_generator.sv =====
`timescale 1ns / 1ps
// From an accepted word to its result, the path runs through 4 front stages, one stage per
// quotient bit of the bus divider, 2 overrun stages, 25 stages of the period rescaling divider
// and 4 output stages.
// Throughput: one word per cycle; a stall at the output freezes the whole pipeline.
// Reset clears every valid bit and loads the registers with 8000, 8000 and 2560.
module svpwm_compare_generator #(
	parameter int VOLT_WIDTH    = 16,
	parameter int COMPARE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                vec_valid,
	output logic                                vec_stall,
	input  logic signed [VOLT_WIDTH-1:0]        v_alpha,
	input  logic signed [VOLT_WIDTH-1:0]        v_beta,
	input  logic [VOLT_WIDTH-1:0]               bus_voltage,
	output logic                                cmp_valid,
	input  logic                                cmp_stall,
	output logic [COMPARE_WIDTH-1:0]            compare_u,
	output logic [COMPARE_WIDTH-1:0]            compare_v,
	output logic [COMPARE_WIDTH-1:0]            compare_w,
	output logic [2:0]                          sector_code,
	output logic                                bus_low,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [svpwm_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int RAW_W = VOLT_WIDTH + 26;
	localparam int SW    = svpwm_pkg::SCALED_W;
	localparam int RW    = svpwm_pkg::RATIO_W;

	// Configuration registers
	logic [COMPARE_WIDTH-1:0] pwm_top_q, mod_period_q;
	logic [VOLT_WIDTH-1:0]    bus_min_q;
	logic [1:0]               reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q    <= COMPARE_WIDTH'(svpwm_pkg::PWM_TOP_RST);
			mod_period_q <= COMPARE_WIDTH'(svpwm_pkg::MOD_PERIOD_RST);
			bus_min_q    <= VOLT_WIDTH'(svpwm_pkg::BUS_MIN_RST);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				svpwm_pkg::REG_PWM_TOP:    pwm_top_q    <= pwdata[COMPARE_WIDTH-1:0];
				svpwm_pkg::REG_MOD_PERIOD: mod_period_q <= pwdata[COMPARE_WIDTH-1:0];
				svpwm_pkg::REG_BUS_MIN:    bus_min_q    <= pwdata[VOLT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			svpwm_pkg::REG_PWM_TOP:    prdata = 32'(pwm_top_q);
			svpwm_pkg::REG_MOD_PERIOD: prdata = 32'(mod_period_q);
			svpwm_pkg::REG_BUS_MIN:    prdata = 32'(bus_min_q);
			default:                   prdata = '0;
		endcase
	end

	// Every stage moves together unless the output word is held.
	logic en;

	assign en        = !(cmp_valid && cmp_stall);
	assign vec_stall = !en;

	logic                  fr_valid;
	logic [RAW_W-1:0]      fr_num1, fr_num2;
	logic [VOLT_WIDTH-1:0] fr_vdc;
	svpwm_pkg::svpwm_ctl_t fr_ctl;

	svpwm_front #(
		.VOLT_WIDTH(VOLT_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vec_valid),
		.v_alpha(v_alpha),
		.v_beta(v_beta),
		.bus_voltage(bus_voltage),
		.bus_minimum(bus_min_q),
		.out_valid(fr_valid),
		.num_1(fr_num1),
		.num_2(fr_num2),
		.vdc(fr_vdc),
		.ctl(fr_ctl)
	);

	logic                  d1_valid;
	logic [RAW_W-1:0]      d1_r1, d1_r2;
	svpwm_pkg::svpwm_ctl_t d1_ctl;

	svpwm_div #(
		.NUM_W(RAW_W),
		.DEN_W(VOLT_WIDTH),
		.QUO_W(RAW_W),
		.SIDE_W($bits(svpwm_pkg::svpwm_ctl_t))
	) u_div_bus (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fr_valid),
		.num_a(fr_num1),
		.num_b(fr_num2),
		.den(fr_vdc),
		.side_in(fr_ctl),
		.out_valid(d1_valid),
		.quo_a(d1_r1),
		.quo_b(d1_r2),
		.side_out(d1_ctl)
	);

	logic                  ov_valid;
	logic [SW-1:0]         ov_s1, ov_s2, ov_sum;
	svpwm_pkg::svpwm_ovr_t ov_side;

	svpwm_ovr #(
		.RAW_W(RAW_W)
	) u_ovr (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(d1_valid),
		.r1(d1_r1),
		.r2(d1_r2),
		.ctl(d1_ctl),
		.out_valid(ov_valid),
		.s1(ov_s1),
		.s2(ov_s2),
		.ssum(ov_sum),
		.side(ov_side)
	);

	logic                  d2_valid;
	logic [RW-1:0]         d2_q1, d2_q2;
	svpwm_pkg::svpwm_ovr_t d2_side;
	logic [SW+23:0]        n2_a, n2_b;

	assign n2_a = {ov_s1, 24'b0};
	assign n2_b = {ov_s2, 24'b0};

	svpwm_div #(
		.NUM_W(SW + svpwm_pkg::FRAC_W),
		.DEN_W(SW),
		.QUO_W(RW),
		.SIDE_W($bits(svpwm_pkg::svpwm_ovr_t))
	) u_div_scale (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(ov_valid),
		.num_a(n2_a),
		.num_b(n2_b),
		.den(ov_sum),
		.side_in(ov_side),
		.out_valid(d2_valid),
		.quo_a(d2_q1),
		.quo_b(d2_q2),
		.side_out(d2_side)
	);

	svpwm_back #(
		.COMPARE_WIDTH(COMPARE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(d2_valid),
		.q1(d2_q1),
		.q2(d2_q2),
		.side(d2_side),
		.pwm_top(pwm_top_q),
		.modulation_period(mod_period_q),
		.out_valid(cmp_valid),
		.compare_u(compare_u),
		.compare_v(compare_v),
		.compare_w(compare_w),
		.sector_code(sector_code),
		.bus_low(bus_low)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY = 77;

	typedef struct {
		logic [15:0] cu;
		logic [15:0] cv;
		logic [15:0] cw;
		logic [2:0]  sec;
		logic        low;
	} compare_word_t;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic [15:0]        vdc;
		logic               known;
		compare_word_t      res;
	} vector_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vec_valid = 1'b0;
	logic vec_stall;
	logic signed [15:0] v_alpha = '0;
	logic signed [15:0] v_beta = '0;
	logic [15:0] bus_voltage = '0;
	logic cmp_valid;
	logic cmp_stall = 1'b0;
	logic [15:0] compare_u, compare_v, compare_w;
	logic [2:0] sector_code;
	logic bus_low;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [svpwm_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Predictor copy of the registers.
	logic [15:0] top_q = 16'(svpwm_pkg::PWM_TOP_RST);
	logic [15:0] period_q = 16'(svpwm_pkg::MOD_PERIOD_RST);
	logic [15:0] bus_min_q = 16'(svpwm_pkg::BUS_MIN_RST);

	compare_word_t pending_words[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;

	svpwm_compare_generator u_top (.*);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [63:0] frac_of_period(input logic [63:0] m,
			input logic [15:0] vdc);
		logic [63:0] z;
		z = (m >> 16) * 64'(svpwm_pkg::SQRT3_Q16) +
			(((m & 64'hFFFF) * 64'(svpwm_pkg::SQRT3_Q16)) >> 16);
		return (z << 8) / vdc;
	endfunction

	function automatic logic [15:0] phase_compare(input logic [63:0] t);
		logic [63:0] c;
		c = (t * period_q + (64'd1 << 25)) >> 26;
		if (c > top_q)
			c = top_q;
		return top_q - c[15:0];
	endfunction

	function automatic compare_word_t predict_compares(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic [15:0] vdc);
		compare_word_t w;
		longint vr2, vr3, bb, m1, m2;
		logic [63:0] r1, r2, sum, ta, tb, tc;
		logic [2:0] sec;
		w.cu = top_q >> 1;
		w.cv = top_q >> 1;
		w.cw = top_q >> 1;
		w.sec = svpwm_pkg::SEC_Z0;
		w.low = 1'b0;
		if (vdc <= bus_min_q) begin
			w.low = 1'b1;
			return w;
		end
		vr2 = longint'(svpwm_pkg::HALF_SQRT3_Q16) * a - 64'sd32768 * b;
		vr3 = -longint'(svpwm_pkg::HALF_SQRT3_Q16) * a - 64'sd32768 * b;
		bb = 64'sd65536 * b;
		sec = {vr3 > 0, vr2 > 0, b > 0};
		w.sec = sec;
		case (sec)
			svpwm_pkg::SEC_1: begin m1 = -vr2; m2 = -vr3; end
			svpwm_pkg::SEC_2: begin m1 = -vr3; m2 = -bb; end
			svpwm_pkg::SEC_3: begin m1 = vr2; m2 = bb; end
			svpwm_pkg::SEC_4: begin m1 = -bb; m2 = -vr2; end
			svpwm_pkg::SEC_5: begin m1 = bb; m2 = vr3; end
			svpwm_pkg::SEC_6: begin m1 = vr3; m2 = vr2; end
			default: return w;
		endcase
		if (m1 < 0) m1 = 0;
		if (m2 < 0) m2 = 0;
		r1 = frac_of_period(m1, vdc);
		r2 = frac_of_period(m2, vdc);
		sum = r1 + r2;
		if (sum > (64'd1 << svpwm_pkg::FRAC_W)) begin
			while ((sum >> svpwm_pkg::SCALED_W) != 0) begin
				r1 = r1 >> 1;
				r2 = r2 >> 1;
				sum = r1 + r2;
			end
			r1 = (r1 << svpwm_pkg::FRAC_W) / sum;
			r2 = (r2 << svpwm_pkg::FRAC_W) / sum;
		end
		ta = (64'd1 << svpwm_pkg::FRAC_W) - r1 - r2;
		tb = ta + 2 * r1;
		tc = tb + 2 * r2;
		case (sec)
			svpwm_pkg::SEC_1: begin w.cu = phase_compare(tb); w.cv = phase_compare(ta);
				w.cw = phase_compare(tc); end
			svpwm_pkg::SEC_2: begin w.cu = phase_compare(ta); w.cv = phase_compare(tc);
				w.cw = phase_compare(tb); end
			svpwm_pkg::SEC_3: begin w.cu = phase_compare(ta); w.cv = phase_compare(tb);
				w.cw = phase_compare(tc); end
			svpwm_pkg::SEC_4: begin w.cu = phase_compare(tc); w.cv = phase_compare(tb);
				w.cw = phase_compare(ta); end
			svpwm_pkg::SEC_5: begin w.cu = phase_compare(tc); w.cv = phase_compare(ta);
				w.cw = phase_compare(tb); end
			default: begin w.cu = phase_compare(tb); w.cv = phase_compare(tc);
				w.cw = phase_compare(ta); end
		endcase
		return w;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= svpwm_pkg::ADDR_W'(idx) << 2;
		pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			svpwm_pkg::REG_PWM_TOP: top_q = value;
			svpwm_pkg::REG_MOD_PERIOD: period_q = value;
			svpwm_pkg::REG_BUS_MIN: bus_min_q = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Sends one word and queues its expectation; the row result is used when known.
	task automatic send_vector(input vector_row_t row);
		compare_word_t w;
		while (($urandom_range(99) < send_idle)) begin
			vec_valid <= 1'b0;
			@(negedge clk);
		end
		w = row.known ? row.res : predict_compares(row.a, row.b, row.vdc);
		v_alpha <= row.a;
		v_beta <= row.b;
		bus_voltage <= row.vdc;
		vec_valid <= 1'b1;
		pending_words.push_back(w);
		@(posedge clk);
		while (vec_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_and_settle();
		int guard;
		guard = 0;
		vec_valid <= 1'b0;
		while (pending_words.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	function automatic vector_row_t random_row();
		vector_row_t r;
		int mode;
		mode = $urandom_range(9);
		r.known = 1'b0;
		r.a = 16'($urandom);
		r.b = 16'($urandom);
		r.vdc = 16'($urandom);
		if (mode < 6) begin
			// Typical operation: moderate command against a healthy bus.
			r.a = 16'(int'($urandom_range(8000)) - 4000);
			r.b = 16'(int'($urandom_range(8000)) - 4000);
			r.vdc = 16'($urandom_range(65535, 2561));
		end else if (mode == 6) begin
			r.vdc = 16'($urandom_range(bus_min_q + 4, bus_min_q > 3 ? bus_min_q - 3 : 0));
		end else if (mode == 7) begin
			r.a = 16'(int'($urandom_range(8)) - 4);
			r.b = 16'(int'($urandom_range(8)) - 4);
		end
		return r;
	endfunction

	// Receiver: random stall, long hold-off when requested, checks at the rising edge.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			cmp_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else
			cmp_stall <= ($urandom_range(99) < recv_stall);
	end

	always @(posedge clk) begin
		compare_word_t w;
		if (arst_n && cmp_valid && !cmp_stall) begin
			if (pending_words.size() == 0) begin
				$display("unexpected compare word at %0t", $realtime);
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (compare_u !== w.cu) report_mismatch("compare_u", compare_u, w.cu);
				if (compare_v !== w.cv) report_mismatch("compare_v", compare_v, w.cv);
				if (compare_w !== w.cw) report_mismatch("compare_w", compare_w, w.cw);
				if (sector_code !== w.sec)
					report_mismatch("sector_code", 16'(sector_code), 16'(w.sec));
				if (bus_low !== w.low) report_mismatch("bus_low", 16'(bus_low), 16'(w.low));
			end
		end
	end

	vector_row_t directed[$];

	function automatic vector_row_t mk(input int a, input int b, input int vdc,
			input bit known = 0, input int cu = 0, input int cv = 0, input int cw = 0,
			input int sec = 0, input bit low = 0);
		vector_row_t r;
		r.a = 16'(a);
		r.b = 16'(b);
		r.vdc = 16'(vdc);
		r.known = known;
		r.res = '{16'(cu), 16'(cv), 16'(cw), 3'(sec), low};
		return r;
	endfunction

	initial begin
		int phase;
		int n;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Low bus and zero vector give neutral compares under reset settings.
		directed.push_back(mk(1000, 1000, 2560, 1, 4000, 4000, 4000, 0, 1));
		directed.push_back(mk(0, 0, 0, 1, 4000, 4000, 4000, 0, 1));
		directed.push_back(mk(0, 0, 24000, 1, 4000, 4000, 4000, 0, 0));
		directed.push_back(mk(-32768, -32768, 2561));
		directed.push_back(mk(32767, 32767, 65535));
		directed.push_back(mk(32767, -32768, 2561));
		directed.push_back(mk(-32768, 32767, 65535));
		directed.push_back(mk(3000, 1000, 24000));
		directed.push_back(mk(0, 3000, 24000));
		directed.push_back(mk(-3000, 1000, 24000));
		directed.push_back(mk(-3000, -1000, 24000));
		directed.push_back(mk(0, -3000, 24000));
		directed.push_back(mk(3000, -1000, 24000));
		directed.push_back(mk(30000, 20000, 3000));
		directed.push_back(mk(1, 0, 24000));
		directed.push_back(mk(0, 1, 24000));
		directed.push_back(mk(-1, -1, 24000));
		foreach (directed[i])
			send_vector(directed[i]);
		drain_and_settle();

		// Settings cycle through extremes, including zero top and zero period.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(svpwm_pkg::REG_PWM_TOP, 16'd0);
					write_reg(svpwm_pkg::REG_BUS_MIN, 16'd0); end
				1: begin write_reg(svpwm_pkg::REG_PWM_TOP, 16'hFFFF);
					write_reg(svpwm_pkg::REG_MOD_PERIOD, 16'd0); end
				2: begin write_reg(svpwm_pkg::REG_MOD_PERIOD, 16'hFFFF);
					write_reg(svpwm_pkg::REG_BUS_MIN, 16'hFFFF); end
				3: begin write_reg(svpwm_pkg::REG_PWM_TOP, 16'd1);
					write_reg(svpwm_pkg::REG_MOD_PERIOD, 16'd1);
					write_reg(svpwm_pkg::REG_BUS_MIN, 16'd100); end
				4: begin write_reg(svpwm_pkg::REG_PWM_TOP, 16'(svpwm_pkg::PWM_TOP_RST));
					write_reg(svpwm_pkg::REG_MOD_PERIOD, 16'(svpwm_pkg::MOD_PERIOD_RST));
					write_reg(svpwm_pkg::REG_BUS_MIN, 16'(svpwm_pkg::BUS_MIN_RST)); end
				default: begin
					write_reg(svpwm_pkg::REG_PWM_TOP, 16'($urandom_range(65535, 1)));
					write_reg(svpwm_pkg::REG_MOD_PERIOD, 16'($urandom_range(65535, 1)));
					write_reg(svpwm_pkg::REG_BUS_MIN, 16'($urandom_range(8000))); end
			endcase
			send_idle = (phase % 4 == 1 || phase % 4 == 3) ? 84 : 0;
			recv_stall = (phase % 4 == 2 || phase % 4 == 3) ? 84 : 0;
			if (phase == 3) begin
				send_idle = 11;
				recv_stall = 11;
			end
			if (phase == 4)
				hold_off = 300;
			n = (phase == 1 || phase == 2) ? 120 : 250;
			repeat (n)
				send_vector(random_row());
			if (phase == 4) begin
				// Sender pauses until the pipeline is empty, then resumes.
				vec_valid <= 1'b0;
				while (pending_words.size() != 0)
					@(negedge clk);
				repeat (50)
					send_vector(random_row());
			end
			drain_and_settle();
		end

		if (pending_words.size() != 0) begin
			$display("%0d compare words never arrived", pending_words.size());
			errors++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
